// ===== sv/irqlcb_pkg.sv =====
// ----------------------------------------------------------------------------
// irqlcb_pkg
// Shared types and constants for the least-count IRQ balancer.
// ----------------------------------------------------------------------------
package irqlcb_pkg;

    localparam int MAX_CORES_DEF  = 16;
    localparam int IRQ_LINES_DEF  = 16;

    localparam int CountW         = 64;
    localparam int PeriodW        = 16;
    localparam int RemBitsPerStep = 4;
    localparam int ApbAddrW       = 4;
    localparam int ApbDataW       = 32;

    localparam logic [CountW-1:0]  COUNT_ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CountW-1:0]  COUNT_CLEAR_AT = 64'hFFFF_FFFF_FFFF_FFFE;
    localparam logic [4:0]         ACTIVE_RESET   = 5'd1;
    localparam logic [PeriodW-1:0] PERIOD_RESET   = 16'd10;

    typedef enum logic [1:0] {
        REG_SYM_IO  = 2'd0,
        REG_BAL_EN  = 2'd1,
        REG_ACTIVE  = 2'd2,
        REG_PERIOD  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [3:0] core_id;
        logic [3:0] irq_line;
        logic       balance_eligible;
    } in_beat_t;

    typedef struct packed {
        logic       eoi_to_local_apic;
        logic       route_valid;
        logic [3:0] route_core;
        logic       counts_cleared;
    } out_beat_t;

    typedef struct packed {
        logic               sym_io;
        logic               bal_en;
        logic [4:0]         active_cores;
        logic [PeriodW-1:0] period;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [CountW-1:0]  dividend;
        logic [PeriodW-1:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_rsp_t;

    typedef enum logic [2:0] {
        ST_WIPE_ALL,
        ST_IDLE,
        ST_INC,
        ST_DIV,
        ST_SCAN,
        ST_WIPE_LINE,
        ST_DONE
    } seq_state_t;

endpackage

// ===== sv/irqlcb_count_ram.sv =====
// ----------------------------------------------------------------------------
// irqlcb_count_ram
// Interrupt count store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module irqlcb_count_ram #(
    parameter int AddrW = 8,
    parameter int DataW = 64
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [DataW-1:0] wdata,
    input  logic [AddrW-1:0] raddr,
    output logic [DataW-1:0] rdata
);

    localparam int Depth = 1 << AddrW;

    logic [DataW-1:0] mem [Depth];
    logic [DataW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/irqlcb_rem_unit.sv =====
// ----------------------------------------------------------------------------
// irqlcb_rem_unit
// Iterative restoring remainder of a 64-bit count by the 16-bit period,
// four quotient bits per cycle.
// ----------------------------------------------------------------------------
module irqlcb_rem_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  irqlcb_pkg::rem_req_t  req,
    output irqlcb_pkg::rem_rsp_t  rsp
);
    import irqlcb_pkg::*;

    localparam int Steps    = CountW / RemBitsPerStep;
    localparam int StepCntW = $clog2(Steps);

    logic [CountW-1:0]   shift_reg, shift_next;
    logic [PeriodW-1:0]  rem_reg, rem_next;
    logic [PeriodW-1:0]  div_reg, div_next;
    logic [StepCntW-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [PeriodW-1:0]  step_rem;

    always_comb
    begin
        logic [PeriodW:0]   trial;
        logic [PeriodW-1:0] r;
        r     = rem_reg;
        trial = '0;
        for (int i = 0; i < RemBitsPerStep; i++)
        begin
            trial = {r, shift_reg[CountW-1-i]};
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            r = trial[PeriodW-1:0];
        end
        step_rem = r;
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        cnt_next   = cnt_reg;
        if (req.start && !busy_reg)
        begin
            busy_next  = 1'b1;
            shift_next = req.dividend;
            rem_next   = '0;
            div_next   = (req.divisor == '0) ? PeriodW'(1) : req.divisor;
            cnt_next   = '0;
        end
        else if (busy_reg)
        begin
            shift_next = shift_reg << RemBitsPerStep;
            rem_next   = step_rem;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == StepCntW'(Steps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

endmodule

// ===== sv/irqlcb_seq.sv =====
// ----------------------------------------------------------------------------
// irqlcb_seq
// Sequencer: reset wipe, count update, period check, least-count scan and line wipe.
// ----------------------------------------------------------------------------
module irqlcb_seq #(
    parameter  int MAX_CORES = irqlcb_pkg::MAX_CORES_DEF,
    parameter  int IRQ_LINES = irqlcb_pkg::IRQ_LINES_DEF,
    localparam int CoreW     = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1,
    localparam int LineW     = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1,
    localparam int AddrW     = CoreW + LineW
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  irqlcb_pkg::cfg_t       cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  irqlcb_pkg::in_beat_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output irqlcb_pkg::out_beat_t  out_data,
    output logic                   mem_we,
    output logic [AddrW-1:0]       mem_waddr,
    output logic [63:0]            mem_wdata,
    output logic [AddrW-1:0]       mem_raddr,
    input  logic [63:0]            mem_rdata,
    output irqlcb_pkg::rem_req_t   rem_req,
    input  irqlcb_pkg::rem_rsp_t   rem_rsp
);
    import irqlcb_pkg::*;

    localparam int NumW = $clog2(MAX_CORES + 1);

    seq_state_t        state_reg, state_next;
    in_beat_t          beat_reg, beat_next;
    logic [NumW-1:0]   n_reg, n_next;
    logic [NumW-1:0]   issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [CoreW-1:0]  pend_idx_reg, pend_idx_next;
    logic [CountW-1:0] min_reg, min_next;
    logic [CoreW-1:0]  best_reg, best_next;
    logic              clr_reg, clr_next;
    logic              route_valid_reg, route_valid_next;
    logic [AddrW-1:0]  wipe_reg, wipe_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    logic              accept;
    logic              in_range;
    logic [NumW-1:0]   n_calc;
    logic [CountW-1:0] cnt_inc;
    logic              check_period;
    logic              scan_lt;
    logic              scan_hi;
    logic              scan_last;
    logic              scan_clr;
    logic              out_free;
    logic [LineW-1:0]  line_idx;
    logic [CoreW-1:0]  core_idx;

    assign accept       = in_valid && in_ready;
    assign in_range     = (int'(in_data.core_id) < MAX_CORES)
                       && (int'(in_data.irq_line) < IRQ_LINES);
    assign line_idx     = LineW'(beat_reg.irq_line);
    assign core_idx     = CoreW'(beat_reg.core_id);
    assign cnt_inc      = mem_rdata + 64'd1;
    assign check_period = cfg.bal_en && beat_reg.balance_eligible && (cnt_inc != '0);
    assign scan_lt      = mem_rdata < min_reg;
    assign scan_hi      = mem_rdata >= COUNT_CLEAR_AT;
    assign scan_last    = pend_reg && (issue_reg == n_reg);
    assign scan_clr     = clr_reg || (pend_reg && !scan_lt && scan_hi);
    assign out_free     = !out_valid_reg || out_ready;

    always_comb
    begin
        int ac;
        ac = int'(cfg.active_cores);
        if (ac == 0)
        begin
            n_calc = NumW'(1);
        end
        else if (ac > MAX_CORES)
        begin
            n_calc = NumW'(MAX_CORES);
        end
        else
        begin
            n_calc = NumW'(ac);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE_ALL:
            begin
                if (wipe_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_range ? ST_INC : ST_DONE;
                end
            end
            ST_INC:
            begin
                state_next = check_period ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (rem_rsp.done)
                begin
                    state_next = rem_rsp.zero ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = scan_clr ? ST_WIPE_LINE : ST_DONE;
                end
            end
            ST_WIPE_LINE:
            begin
                if (issue_reg == n_reg - 1'b1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = {core_idx, line_idx};
        mem_wdata        = '0;
        mem_raddr        = {core_idx, line_idx};
        rem_req.start    = 1'b0;
        rem_req.dividend = cnt_inc;
        rem_req.divisor  = cfg.period;
        unique case (state_reg)
            ST_WIPE_ALL:
            begin
                mem_we    = 1'b1;
                mem_waddr = wipe_reg;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                mem_raddr = {CoreW'(in_data.core_id), LineW'(in_data.irq_line)};
            end
            ST_INC:
            begin
                mem_we        = 1'b1;
                mem_wdata     = cnt_inc;
                rem_req.start = check_period;
            end
            ST_SCAN:
            begin
                mem_raddr = {issue_reg[CoreW-1:0], line_idx};
            end
            ST_WIPE_LINE:
            begin
                mem_we    = 1'b1;
                mem_waddr = {issue_reg[CoreW-1:0], line_idx};
            end
            ST_DIV, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // datapath
    always_comb
    begin
        beat_next        = beat_reg;
        n_next           = n_reg;
        issue_next       = issue_reg;
        pend_next        = pend_reg;
        pend_idx_next    = pend_idx_reg;
        min_next         = min_reg;
        best_next        = best_reg;
        clr_next         = clr_reg;
        route_valid_next = route_valid_reg;
        wipe_next        = wipe_reg;
        out_next         = out_reg;
        out_valid_next   = out_valid_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_WIPE_ALL:
            begin
                wipe_next = wipe_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    beat_next        = in_data;
                    n_next           = n_calc;
                    issue_next       = '0;
                    pend_next        = 1'b0;
                    min_next         = COUNT_ALL_ONES;
                    best_next        = '0;
                    clr_next         = 1'b0;
                    route_valid_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (rem_rsp.done && rem_rsp.zero)
                begin
                    route_valid_next = 1'b1;
                end
            end
            ST_SCAN:
            begin
                if (issue_reg < n_reg)
                begin
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[CoreW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (scan_lt)
                    begin
                        min_next  = mem_rdata;
                        best_next = pend_idx_reg;
                    end
                    else if (scan_hi)
                    begin
                        clr_next = 1'b1;
                    end
                end
                if (scan_last)
                begin
                    issue_next = '0;
                end
            end
            ST_WIPE_LINE:
            begin
                issue_next = issue_reg + 1'b1;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_next.eoi_to_local_apic = cfg.sym_io;
                    out_next.route_valid       = route_valid_reg;
                    out_next.route_core        = route_valid_reg ? 4'(best_reg) : 4'd0;
                    out_next.counts_cleared    = route_valid_reg && clr_reg;
                end
            end
            ST_INC:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_WIPE_ALL;
            wipe_reg        <= '0;
            issue_reg       <= '0;
            pend_reg        <= 1'b0;
            clr_reg         <= 1'b0;
            route_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            wipe_reg        <= wipe_next;
            issue_reg       <= issue_next;
            pend_reg        <= pend_next;
            clr_reg         <= clr_next;
            route_valid_reg <= route_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg     <= beat_next;
        n_reg        <= n_next;
        pend_idx_reg <= pend_idx_next;
        min_reg      <= min_next;
        best_reg     <= best_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_INC || state_reg == ST_DONE))
        else $error("accepted beat did not start processing");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !mem_we)
        else $error("count store written during scan");

    a_rem_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        rem_req.start |-> (state_reg == ST_INC && !rem_rsp.busy))
        else $error("remainder unit started while busy");

    a_wipe_needs_route: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WIPE_LINE |-> (clr_reg && route_valid_reg))
        else $error("line wipe without a clearing scan");

    a_no_route_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.route_valid)
            |-> (out_data.route_core == 4'd0 && !out_data.counts_cleared))
        else $error("route fields set without a route");

endmodule

// ===== sv/irq_least_count_balancer.sv =====
// ----------------------------------------------------------------------------
// irq_least_count_balancer
// Per-core, per-line interrupt counting with least-count rerouting.
//
// After reset the count store is cleared one entry a cycle, through all of its
// 2^AddrW entries (256 at the defaults); in_ready stays low meanwhile and
// register writes are taken as ever. One beat is then handled at a time. A
// beat with an out-of-range core or line goes straight to the result state;
// any other beat has its count updated first and then goes to the result
// state when it does not reach the period check. One that does is handed to
// the remainder unit, which works through the 64-bit count in sixteen
// four-bit steps; a due rebalance then scans the n active cores through the
// count store's read port and, when a count at or above COUNT_CLEAR_AT is met
// that is not a new minimum, zeroes the line's counts for those n cores.
// in_ready returns in the same cycle as the new result beat appears on
// out_data; while the previous result beat is still held by out_ready, the
// block waits in its result state.
// ----------------------------------------------------------------------------
module irq_least_count_balancer #(
    parameter int MAX_CORES = irqlcb_pkg::MAX_CORES_DEF,
    parameter int IRQ_LINES = irqlcb_pkg::IRQ_LINES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [irqlcb_pkg::ApbAddrW-1:0]     paddr,
    input  logic [irqlcb_pkg::ApbDataW-1:0]     pwdata,
    output logic [irqlcb_pkg::ApbDataW-1:0]     prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  irqlcb_pkg::in_beat_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output irqlcb_pkg::out_beat_t               out_data
);
    import irqlcb_pkg::*;

    localparam int CoreW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int LineW = (IRQ_LINES > 1) ? $clog2(IRQ_LINES) : 1;
    localparam int AddrW = CoreW + LineW;

    logic               sym_io_reg, sym_io_next;
    logic               bal_en_reg, bal_en_next;
    logic [4:0]         active_reg, active_next;
    logic [PeriodW-1:0] period_reg, period_next;
    logic               wr_en;
    reg_idx_t           reg_idx;
    cfg_t               cfg;

    logic               mem_we;
    logic [AddrW-1:0]   mem_waddr;
    logic [CountW-1:0]  mem_wdata;
    logic [AddrW-1:0]   mem_raddr;
    logic [CountW-1:0]  mem_rdata;
    rem_req_t           rem_req;
    rem_rsp_t           rem_rsp;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        sym_io_next = sym_io_reg;
        bal_en_next = bal_en_reg;
        active_next = active_reg;
        period_next = period_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_SYM_IO: sym_io_next = pwdata[0];
                REG_BAL_EN: bal_en_next = pwdata[0];
                REG_ACTIVE: active_next = pwdata[4:0];
                REG_PERIOD: period_next = pwdata[PeriodW-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_SYM_IO: prdata = ApbDataW'(sym_io_reg);
            REG_BAL_EN: prdata = ApbDataW'(bal_en_reg);
            REG_ACTIVE: prdata = ApbDataW'(active_reg);
            REG_PERIOD: prdata = ApbDataW'(period_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_io_reg <= 1'b0;
            bal_en_reg <= 1'b0;
            active_reg <= ACTIVE_RESET;
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            sym_io_reg <= sym_io_next;
            bal_en_reg <= bal_en_next;
            active_reg <= active_next;
            period_reg <= period_next;
        end
    end

    assign cfg.sym_io       = sym_io_reg;
    assign cfg.bal_en       = bal_en_reg;
    assign cfg.active_cores = active_reg;
    assign cfg.period       = period_reg;

    irqlcb_count_ram #(
        .AddrW (AddrW),
        .DataW (CountW)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    irqlcb_rem_unit u_rem_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    irqlcb_seq #(
        .MAX_CORES (MAX_CORES),
        .IRQ_LINES (IRQ_LINES)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .rem_req   (rem_req),
        .rem_rsp   (rem_rsp)
    );

endmodule

// ===== test/tb_irq_least_count_balancer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_irq_least_count_balancer
// Self-checking bench for the least-count IRQ balancer. A short table of
// directed beats and register writes comes first. Random beats follow over
// several register settings and idling phases, and one long output hold-off
// backs the block up. Every result beat is checked field by field against a
// fixed row's expectation, else an in-bench model of per-core, per-line counts.
// ----------------------------------------------------------------------------
module tb_irq_least_count_balancer;
    import irqlcb_pkg::*;

    localparam int NCORES     = 16;
    localparam int NLINES     = 16;
    localparam int PLAN_LEN   = 35;
    localparam int SUB_PHASES = 8;
    localparam int SUB_BEATS  = 63;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 400;
    localparam int TAIL_LEN   = 64;

    typedef struct packed {
        logic      is_cfg;
        reg_idx_t  idx;
        logic [31:0] val;
        in_beat_t  beat;
        logic      fixed;
        out_beat_t want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ApbAddrW-1:0] paddr = '0;
    logic [ApbDataW-1:0] pwdata = '0;
    logic [ApbDataW-1:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_beat_t out_data;

    // typed expectation travelling with the beat on the input side
    logic beat_fixed = 1'b0;
    out_beat_t beat_want = '0;

    logic [CountW-1:0] line_counts [NCORES][NLINES];
    logic cur_sym_io;
    logic cur_bal_en;
    logic [4:0] cur_active;
    logic [PeriodW-1:0] cur_period;

    out_beat_t pending_routes [$];
    int beats_in = 0;
    int results_out = 0;
    int errs = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    logic pressure_req = 1'b0;
    logic pressure_served = 1'b0;

    plan_row_t plan_tab [PLAN_LEN];

    irq_least_count_balancer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic out_beat_t predict_route(input in_beat_t b);
        out_beat_t r;
        logic [CountW-1:0] cnt;
        logic [CountW-1:0] per;
        logic [CountW-1:0] lo;
        logic wipe;
        int n;
        int best;
        r = '0;
        r.eoi_to_local_apic = cur_sym_io;
        cnt = line_counts[b.core_id][b.irq_line] + 64'd1;
        line_counts[b.core_id][b.irq_line] = cnt;
        per = (cur_period == '0) ? 64'd1 : {48'd0, cur_period};
        if (cur_bal_en && b.balance_eligible && cnt != '0 && (cnt % per) == '0)
        begin
            n = (cur_active == 5'd0) ? 1 : ((cur_active > NCORES) ? NCORES : int'(cur_active));
            lo = COUNT_ALL_ONES;
            best = 0;
            wipe = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (line_counts[i][b.irq_line] < lo)
                begin
                    lo = line_counts[i][b.irq_line];
                    best = i;
                end
                else if (line_counts[i][b.irq_line] >= COUNT_CLEAR_AT)
                    wipe = 1'b1;
            end
            if (wipe)
                for (int i = 0; i < n; i++)
                    line_counts[i][b.irq_line] = '0;
            r.route_valid = 1'b1;
            r.route_core = best[3:0];
            r.counts_cleared = wipe;
        end
        return r;
    endfunction

    // input side: predict on accept; output side: check against oldest
    always @(posedge clk)
    begin
        out_beat_t p;
        out_beat_t w;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                p = predict_route(in_data);
                pending_routes.push_back(beat_fixed ? beat_want : p);
            end
            if (out_valid && out_ready)
            begin
                results_out <= results_out + 1;
                if (pending_routes.size() == 0)
                begin
                    $error("unexpected result beat %h", out_data);
                    errs++;
                end
                else
                begin
                    w = pending_routes.pop_front();
                    if (out_data.eoi_to_local_apic !== w.eoi_to_local_apic)
                    begin
                        $error("eoi_to_local_apic: expected %0d, got %0d",
                               w.eoi_to_local_apic, out_data.eoi_to_local_apic);
                        errs++;
                    end
                    if (out_data.route_valid !== w.route_valid)
                    begin
                        $error("route_valid: expected %0d, got %0d",
                               w.route_valid, out_data.route_valid);
                        errs++;
                    end
                    if (out_data.route_core !== w.route_core)
                    begin
                        $error("route_core: expected %0d, got %0d",
                               w.route_core, out_data.route_core);
                        errs++;
                    end
                    if (out_data.counts_cleared !== w.counts_cleared)
                    begin
                        $error("counts_cleared: expected %0d, got %0d",
                               w.counts_cleared, out_data.counts_cleared);
                        errs++;
                    end
                end
            end
        end
    end

    // output side back-pressure, with one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (pressure_req && !pressure_served)
            begin
                out_ready <= 1'b0;
                hold_left = HOLD_LEN;
                pressure_served = 1'b1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    function automatic plan_row_t cfg_row(input reg_idx_t idx, input logic [31:0] v);
        plan_row_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = v;
        return r;
    endfunction

    function automatic plan_row_t beat_row(input int core, input int line, input logic elig);
        plan_row_t r;
        r = '0;
        r.beat.core_id = core[3:0];
        r.beat.irq_line = line[3:0];
        r.beat.balance_eligible = elig;
        return r;
    endfunction

    function automatic plan_row_t fixed_row(input int core, input int line, input logic elig,
                                            input logic eoi, input logic rv, input int rc);
        plan_row_t r;
        r = beat_row(core, line, elig);
        r.fixed = 1'b1;
        r.want.eoi_to_local_apic = eoi;
        r.want.route_valid = rv;
        r.want.route_core = rc[3:0];
        return r;
    endfunction

    task automatic send_beat(input in_beat_t b, input logic fx, input out_beat_t w);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        beat_fixed <= fx;
        beat_want <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_in++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (results_out != beats_in)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SYM_IO: cur_sym_io = v[0];
            REG_BAL_EN: cur_bal_en = v[0];
            REG_ACTIVE: cur_active = v[4:0];
            REG_PERIOD: cur_period = v[15:0];
            default: ;
        endcase
    endtask

    initial
    begin
        in_beat_t b;
        int act;
        int per;
        for (int c = 0; c < NCORES; c++)
            for (int l = 0; l < NLINES; l++)
                line_counts[c][l] = '0;
        cur_sym_io = 1'b0;
        cur_bal_en = 1'b0;
        cur_active = ACTIVE_RESET;
        cur_period = PERIOD_RESET;

        plan_tab = '{
            fixed_row(0, 0, 1'b1, 1'b0, 1'b0, 0),      // balancing off after reset
            fixed_row(15, 15, 1'b0, 1'b0, 1'b0, 0),
            fixed_row(15, 0, 1'b1, 1'b0, 1'b0, 0),
            cfg_row(REG_SYM_IO, 32'd1),
            cfg_row(REG_BAL_EN, 32'd1),
            cfg_row(REG_PERIOD, 32'd1),
            cfg_row(REG_ACTIVE, 32'd16),
            beat_row(0, 3, 1'b1),
            fixed_row(5, 3, 1'b0, 1'b1, 1'b0, 0),      // timer tick
            fixed_row(15, 15, 1'b1, 1'b1, 1'b1, 0),
            cfg_row(REG_ACTIVE, 32'd0),                // read as one core
            fixed_row(7, 2, 1'b1, 1'b1, 1'b1, 0),
            cfg_row(REG_ACTIVE, 32'd31),               // clamped to all cores
            beat_row(0, 2, 1'b1),
            beat_row(1, 2, 1'b1),
            cfg_row(REG_ACTIVE, 32'd2),
            beat_row(9, 4, 1'b1),                      // core beyond the scan
            cfg_row(REG_PERIOD, 32'd0),                // read as one
            beat_row(3, 5, 1'b1),
            beat_row(3, 5, 1'b1),
            cfg_row(REG_PERIOD, 32'd2),
            beat_row(4, 6, 1'b1),
            beat_row(4, 6, 1'b1),
            cfg_row(REG_PERIOD, 32'd65535),
            fixed_row(10, 7, 1'b1, 1'b1, 1'b0, 0),
            cfg_row(REG_SYM_IO, 32'd0),
            fixed_row(15, 15, 1'b1, 1'b0, 1'b0, 0),
            cfg_row(REG_BAL_EN, 32'd0),
            cfg_row(REG_PERIOD, 32'd1),
            fixed_row(0, 0, 1'b1, 1'b0, 1'b0, 0),
            cfg_row(REG_BAL_EN, 32'd1),
            cfg_row(REG_ACTIVE, 32'd16),
            beat_row(15, 15, 1'b1),
            beat_row(0, 15, 1'b1),
            beat_row(8, 9, 1'b1)
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan_tab[k])
        begin
            if (plan_tab[k].is_cfg)
            begin
                drain();
                write_reg(plan_tab[k].idx, plan_tab[k].val);
            end
            else
                send_beat(plan_tab[k].beat, plan_tab[k].fixed, plan_tab[k].want);
        end

        for (int k = 0; k < SUB_PHASES; k++)
        begin
            drain();
            case (k / 2)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 51; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 51; end
                default: begin send_idle = 17; recv_stall = 17; end
            endcase
            case (k)
                0: act = 16;
                1: act = 1;
                2: act = 31;
                3: act = 0;
                default: act = $urandom_range(2, 16);
            endcase
            case (k)
                1: per = 65535;
                2: per = 0;
                6: per = $urandom_range(1, 65535);
                default: per = $urandom_range(1, 4);
            endcase
            // stray upper bits must be ignored by the block
            write_reg(REG_SYM_IO, ($urandom() & ~32'h1) | 32'($urandom_range(1)));
            write_reg(REG_BAL_EN, ($urandom() & ~32'h1) | ((k == 5) ? 32'd0 : 32'd1));
            write_reg(REG_ACTIVE, ($urandom() & ~32'h1F) | 32'(act));
            write_reg(REG_PERIOD, ($urandom() & ~32'hFFFF) | 32'(per));
            if (k == 0)
                pressure_req = 1'b1;
            for (int j = 0; j < SUB_BEATS; j++)
            begin
                b.core_id = 4'($urandom_range(15));
                b.irq_line = ($urandom_range(9) < 7) ? 4'($urandom_range(3))
                                                     : 4'($urandom_range(15));
                b.balance_eligible = ($urandom_range(4) != 0);
                send_beat(b, 1'b0, '0);
            end
        end

        drain();
        repeat (TAIL_LEN) @(posedge clk);
        if (errs == 0 && pending_routes.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/irqlcb_pkg.sv
sv/irqlcb_count_ram.sv
sv/irqlcb_rem_unit.sv
sv/irqlcb_seq.sv
sv/irq_least_count_balancer.sv
test/tb_irq_least_count_balancer.sv
